FILE: hw/rtl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types, widths and helpers of the sorted key table.
// ----------------------------------------------------------------------------
package sks_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned KB_W   = 4;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  localparam logic [KB_W-1:0] KB_RESET = 4'd8;

  // Cell controls, one group broadcast to every cell.
  typedef struct packed {
    logic load;   // latch compare flags against the search key
    logic shift;  // move flags one cell toward the head
    logic write;  // open a slot at the insert position
  } sks_ctl_t;

  // Mask of the low key_bytes bytes; 0 acts as 1, 9..15 act as 8.
  function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] kb);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if ((b == 0) || (KB_W'(b) < kb)) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/sorted_key_table_search_insert_core.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert_core
// Sorted key table: lower-bound search with optional insert, built as a
// row of slot cells.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  s_axis   | in  | tdata: key[63:0]; tuser: insert_if_missing
//  m_axis   | out | tdata: position[6:0], status[8:7], zeros[15:9];
//           |     | tuser: found
//  cfg      | in  | cfg_wdata_i: key_bytes, written when cfg_we_i is high
//
// An item passes through the load and scan states, then write when it inserts,
// then done: every cell compares at once, then the compare flags shift one
// cell a cycle toward the head until the first hit or the fill count is seen.
// Insert moves all later slots up one place at once, in the write state.
// Reset empties the table; key_bytes returns to 8. No clearing pass.
// A stalled result holds the block before the next input is taken.
// ----------------------------------------------------------------------------
module sorted_key_table_search_insert_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,    // key_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] key
  input  logic        s_axis_tuser,   // [0] insert_if_missing
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] position, [8:7] status, zero
  output logic        m_axis_tuser    // [0] found
);
  import sks_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [KB_W-1:0]    kb_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   pos_q;
  logic [KEY_W-1:0]   key_q;
  logic               ins_q;
  logic               found_q;
  logic [STAT_W-1:0]  status_q;
  logic               out_vld_q;
  logic [POS_W-1:0]   out_pos_q;
  logic [STAT_W-1:0]  out_stat_q;
  logic               out_found_q;

  sks_ctl_t           ctl;
  logic [KEY_W-1:0]   mask;
  logic [KEY_W-1:0]   key_w [DEPTH+1];
  logic               hit_w [DEPTH+1];
  logic               eq_w  [DEPTH+1];
  logic               stop;

  assign mask = key_mask(kb_q);

  assign ctl.load  = (state_q == S_LOAD);
  assign ctl.shift = (state_q == S_SCAN) && !stop;
  assign ctl.write = (state_q == S_WRITE);

  // Cell 0 sees the search key as its left neighbor; never used there.
  assign key_w[0]     = key_q;
  assign hit_w[DEPTH] = 1'b0;
  assign eq_w[DEPTH]  = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sks_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .live_i     (CNT_W'(i) < count_q),
      .mask_i     (mask),
      .srch_key_i (key_q),
      .ins_pos_i  (pos_q),
      .left_key_i (key_w[i]),
      .hit_nxt_i  (hit_w[i+1]),
      .eq_nxt_i   (eq_w[i+1]),
      .key_o      (key_w[i+1]),
      .hit_o      (hit_w[i]),
      .eq_o       (eq_w[i])
    );
  end

  // Head cell carries the flags of slot pos_q during the scan.
  assign stop = hit_w[0] || (pos_q == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kb_q        <= KB_RESET;
      count_q     <= '0;
      pos_q       <= '0;
      out_vld_q   <= 1'b0;
      key_q       <= '0;
      ins_q       <= 1'b0;
      found_q     <= 1'b0;
      status_q    <= ST_FOUND;
      out_pos_q   <= '0;
      out_stat_q  <= ST_FOUND;
      out_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        kb_q <= cfg_wdata_i;
      end
      // S_DONE reloads the output register itself
      if (out_vld_q && m_axis_tready && (state_q != S_DONE)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            key_q   <= s_axis_tdata & mask;
            ins_q   <= s_axis_tuser;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          pos_q   <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (stop) begin
            found_q <= hit_w[0] && eq_w[0];
            if (hit_w[0] && eq_w[0]) begin
              status_q <= ST_FOUND;
              state_q  <= S_DONE;
            end else if (!ins_q) begin
              status_q <= ST_ABSENT;
              state_q  <= S_DONE;
            end else if (count_q == CNT_W'(DEPTH)) begin
              status_q <= ST_FULL;
              state_q  <= S_DONE;
            end else begin
              status_q <= ST_INSERTED;
              state_q  <= S_WRITE;
            end
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        S_WRITE: begin
          count_q <= count_q + 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_vld_q || m_axis_tready) begin
            out_vld_q   <= 1'b1;
            out_found_q <= found_q;
            out_pos_q   <= POS_W'(pos_q);
            out_stat_q  <= status_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {7'd0, out_stat_q, out_pos_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above table depth");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.write |-> (count_q < CNT_W'(DEPTH)))
    else $error("insert into a full table");

  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.write |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the table");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (pos_q <= count_q))
    else $error("scan ran past the fill count");

  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && found_q) |-> (status_q == ST_FOUND))
    else $error("found result with wrong status");

endmodule

FILE: hw/rtl/sks_cell.sv
// ----------------------------------------------------------------------------
// sks_cell
// One table slot: stored key, compare flags that ripple toward the head,
// and the shift-up path used on insert.
// ----------------------------------------------------------------------------
module sks_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sks_pkg::sks_ctl_t      ctl_i,
  input  logic                   live_i,      // slot holds a table entry
  input  logic [sks_pkg::KEY_W-1:0] mask_i,
  input  logic [sks_pkg::KEY_W-1:0] srch_key_i, // already masked
  input  logic [CNT_W-1:0]       ins_pos_i,
  input  logic [sks_pkg::KEY_W-1:0] left_key_i, // key of slot IDX-1
  input  logic                   hit_nxt_i,   // flags of slot IDX+1
  input  logic                   eq_nxt_i,
  output logic [sks_pkg::KEY_W-1:0] key_o,
  output logic                   hit_o,
  output logic                   eq_o
);
  import sks_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic             hit_q, eq_q;
  logic [KEY_W-1:0] cmp_key;
  logic             at_pos, above_pos;

  assign cmp_key   = key_q & mask_i;
  assign at_pos    = (CNT_W'(IDX) == ins_pos_i);
  assign above_pos = (CNT_W'(IDX) >  ins_pos_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      eq_q  <= 1'b0;
    end else if (ctl_i.load) begin
      hit_q <= live_i && (cmp_key >= srch_key_i);
      eq_q  <= live_i && (cmp_key == srch_key_i);
    end else if (ctl_i.shift) begin
      hit_q <= hit_nxt_i;
      eq_q  <= eq_nxt_i;
    end
  end

  // Payload: no reset, slots above the fill count are never read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.write) begin
      if (at_pos) begin
        key_q <= srch_key_i;
      end else if (above_pos) begin
        key_q <= left_key_i;
      end
    end
  end

  assign key_o = key_q;
  assign hit_o = hit_q;
  assign eq_o  = eq_q;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives lookups and inserts into the sorted key table under several key
// widths. Result beats are checked against a local model or typed values.
// ----------------------------------------------------------------------------
module testbench;
  import sks_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDLE_PCT    = 12;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 95;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  pos;
    logic [STAT_W-1:0] status;
  } lookup_res_t;

  typedef struct packed {
    logic             set_kb;
    logic [KB_W-1:0]  kb;
    logic [KEY_W-1:0] key;
    logic             ins;
    logic             typed;
    lookup_res_t      want;
  } probe_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [KB_W-1:0]   cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [KEY_W-1:0]  s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tuser;

  // Local copy of the table and of key_bytes
  logic [KEY_W-1:0]  key_store [TABLE_DEPTH];
  int unsigned       stored_count = 0;
  logic [KB_W-1:0]   kb_cfg       = KB_RESET;

  lookup_res_t       pending_lookups [$];
  int unsigned       mismatch_count = 0;
  bit                steady         = 1'b0;
  bit                hold_req       = 1'b0;

  logic [KB_W-1:0]   phase_kb [12] = '{4'd8, 4'd8, 4'd3, 4'd1, 4'd4, 4'd0,
                                       4'd6, 4'd2, 4'd7, 4'd5, 4'd12, 4'd8};

  sorted_key_table_search_insert_core #(
    .DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [63:0] key
    .s_axis_tuser  (s_axis_tuser),   // [0] insert_if_missing
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [6:0] position, [8:7] status
    .m_axis_tuser  (m_axis_tuser)    // [0] found
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [KEY_W-1:0] mask_for(logic [KB_W-1:0] kb);
    int unsigned nbytes;
    nbytes = (kb == 0) ? 1 : (kb > 8) ? 8 : kb;
    return (nbytes == 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * nbytes)) - 64'd1);
  endfunction

  // Lower-bound search in index order under the current mask, then insert when asked, absent and not full.
  function automatic lookup_res_t predict_lookup(logic [KEY_W-1:0] key, logic ins);
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] k;
    int unsigned      lb;
    lookup_res_t      r;
    m  = mask_for(kb_cfg);
    k  = key & m;
    lb = stored_count;
    for (int i = 0; i < stored_count; i++) begin
      if ((lb == stored_count) && ((key_store[i] & m) >= k)) lb = i;
    end
    r.found = 1'b0;
    r.pos   = POS_W'(lb);
    if ((lb < stored_count) && ((key_store[lb] & m) == k)) begin
      r.found  = 1'b1;
      r.status = ST_FOUND;
    end else if (!ins) begin
      r.status = ST_ABSENT;
    end else if (stored_count >= TABLE_DEPTH) begin
      r.status = ST_FULL;
    end else begin
      for (int i = stored_count; i > lb; i--) key_store[i] = key_store[i-1];
      key_store[lb] = k;
      stored_count++;
      r.status = ST_INSERTED;
    end
    return r;
  endfunction

  // Mostly keys near what is stored, with random bits above the mask.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] k;
    int unsigned      sel;
    m   = mask_for(kb_cfg);
    k   = {$urandom, $urandom};
    sel = $urandom_range(99);
    if ((stored_count > 0) && (sel < 55)) begin
      k = (k & ~m) | (key_store[$urandom_range(stored_count - 1)] & m);
      if (sel >= 35) k = (k & ~m) | ((k + (sel[0] ? 64'd1 : -64'd1)) & m);
    end else if (sel < 70) begin
      k = $urandom_range(1) ? 64'($urandom_range(3)) : ~64'($urandom_range(3));
    end
    return k;
  endfunction

  function automatic probe_row_t row(logic set_kb, logic [KB_W-1:0] kb,
                                     logic [KEY_W-1:0] key, logic ins, logic typed,
                                     logic f, logic [POS_W-1:0] p,
                                     logic [STAT_W-1:0] s);
    probe_row_t r;
    r.set_kb = set_kb;
    r.kb     = kb;
    r.key    = key;
    r.ins    = ins;
    r.typed  = typed;
    r.want   = '{found: f, pos: p, status: s};
    return r;
  endfunction

  function automatic void flag_mismatch(string what, logic [KEY_W-1:0] want,
                                        logic [KEY_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_lookups.size() != 0);
  endtask

  task automatic write_key_bytes(logic [KB_W-1:0] kb);
    wait_all_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= kb;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    kb_cfg       = kb;
  endtask

  // Offers one beat; tvalid stays high into the next call unless a gap falls.
  task automatic send_item(logic [KEY_W-1:0] key, logic ins, logic typed,
                           lookup_res_t want);
    lookup_res_t pred;
    if (!steady && ($urandom_range(99) < IDLE_PCT)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= ins;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    pred = predict_lookup(key, ins);
    pending_lookups.push_back(typed ? want : pred);
  endtask

  // Result side: check accepted beats, then pick the next tready.
  initial begin
    lookup_res_t want;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && (m_axis_tvalid === 1'b1) && m_axis_tready) begin
        if (pending_lookups.size() == 0) begin
          flag_mismatch("unexpected beat", '0, KEY_W'(m_axis_tdata));
        end else begin
          want = pending_lookups.pop_front();
          if (m_axis_tuser !== want.found)
            flag_mismatch("found", KEY_W'(want.found), KEY_W'(m_axis_tuser));
          if (m_axis_tdata[6:0] !== want.pos)
            flag_mismatch("position", KEY_W'(want.pos), KEY_W'(m_axis_tdata[6:0]));
          if (m_axis_tdata[8:7] !== want.status)
            flag_mismatch("status", KEY_W'(want.status), KEY_W'(m_axis_tdata[8:7]));
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    probe_row_t probe_rows [$];
    probe_row_t pr;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, extremes, duplicates, then width changes on a filled table
    probe_rows.push_back(row(0, 0, 64'h0, 0, 1, 0, 0, ST_ABSENT));
    probe_rows.push_back(row(0, 0, '1, 0, 1, 0, 0, ST_ABSENT));
    probe_rows.push_back(row(0, 0, '1, 1, 1, 0, 0, ST_INSERTED));
    probe_rows.push_back(row(0, 0, 64'h0, 1, 1, 0, 0, ST_INSERTED));
    probe_rows.push_back(row(0, 0, 64'h0, 0, 1, 1, 0, ST_FOUND));
    probe_rows.push_back(row(0, 0, '1, 1, 1, 1, 1, ST_FOUND));
    probe_rows.push_back(row(0, 0, 64'h8000_0000_0000_0000, 1, 1, 0, 1, ST_INSERTED));
    probe_rows.push_back(row(0, 0, 64'h0000_0000_0000_00A5, 1, 0, 0, 0, 0));
    probe_rows.push_back(row(0, 0, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0, 0));
    probe_rows.push_back(row(0, 0, 64'h0123_4567_89AB_CDEF, 1, 0, 0, 0, 0));
    probe_rows.push_back(row(1, 4'd1, 64'h0000_0000_0000_00FF, 0, 0, 0, 0, 0));
    probe_rows.push_back(row(0, 0, 64'h1234_5678_9ABC_DEA5, 0, 0, 0, 0, 0));
    probe_rows.push_back(row(0, 0, 64'h0000_0000_0000_0077, 1, 0, 0, 0, 0));
    probe_rows.push_back(row(1, 4'd0, 64'hFFFF_FFFF_FFFF_FF00, 0, 0, 0, 0, 0));
    probe_rows.push_back(row(0, 0, 64'h0000_0000_0000_0042, 1, 0, 0, 0, 0));
    probe_rows.push_back(row(1, 4'd15, 64'h0000_0000_0000_0042, 0, 0, 0, 0, 0));
    probe_rows.push_back(row(0, 0, 64'hDEAD_BEEF_0000_0042, 1, 0, 0, 0, 0));
    probe_rows.push_back(row(1, 4'd9, '1, 0, 0, 0, 0, 0));
    probe_rows.push_back(row(1, 4'd2, 64'h0000_0000_0000_00EF, 1, 0, 0, 0, 0));
    probe_rows.push_back(row(0, 0, 64'hFFFF_FFFF_FFFF_CDEF, 0, 0, 0, 0, 0));
    probe_rows.push_back(row(1, 4'd8, 64'h0, 0, 0, 0, 0, 0));

    foreach (probe_rows[i]) begin
      pr = probe_rows[i];
      if (pr.set_kb) write_key_bytes(pr.kb);
      send_item(pr.key, pr.ins, pr.typed, pr.want);
    end

    // Random phases: the table fills early, later phases run mostly full
    foreach (phase_kb[ph]) begin
      write_key_bytes(phase_kb[ph]);
      steady = (ph == 4);
      if ((ph == 2) || (ph == 9)) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((ph == 6) && (n == 40)) wait_all_results();
        send_item(pick_key(), $urandom_range(99) < 30, 1'b0, '0);
      end
    end
    steady = 1'b0;

    wait_all_results();
    repeat (80) @(posedge clk_i);
    if ((mismatch_count == 0) && (pending_lookups.size() == 0)) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sorted_key_table_search_insert_core.f
hw/rtl/sks_pkg.sv
hw/rtl/sks_cell.sv
hw/rtl/sorted_key_table_search_insert_core.sv
verif/testbench.sv
